// File: hdl/fwrt_pkg.sv
// ----------------------------------------------------------------------------
// Firewall rule table package
// Shared types, codes and defaults for the first-match rule table.
// ----------------------------------------------------------------------------
`default_nettype none

package fwrt_pkg;

  // Default table depth.
  localparam int MAX_RULES_DEF = 64;

  // Operation codes carried in a command.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_CHECK = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_ADDED    = 3'd0,
    STS_INVALID  = 3'd1,
    STS_ACCEPTED = 3'd2,
    STS_REJECTED = 3'd3,
    STS_DELETED  = 3'd4,
    STS_NOTFOUND = 3'd5,
    STS_FLUSHED  = 3'd6,
    STS_FULL     = 3'd7
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PICK,
    ST_APPLY
  } state_t;

  // One command transaction.
  typedef struct packed {
    logic [1:0]  op;
    logic        is_range;
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] match_index;
  } rsp_t;

  // One stored rule.
  typedef struct packed {
    logic        range_flag;
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } rule_t;

  // Per-cell write controls.
  typedef struct packed {
    logic load;   // take the new rule
    logic shift;  // take the upper neighbor's rule
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/firewall_rule_table_unit.sv
// ----------------------------------------------------------------------------
// Firewall rule table unit
// First-match classifier over a chain of rule cells with add, delete by
// shifting down, check and flush.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  command   start / busy        cmd    (req_t)
//  result    done (strobe)       result (rsp_t)
//
// Every command runs from acceptance to the next possible one through these
// steps: compare in all cells, pick the first match, apply the update, then the
// result strobe, which coincides with busy falling.
// The cells compare in parallel; the first-match pick over the match vector
// sets the middle stage.
// Reset empties the table at once; rule storage itself is not cleared.
// Results are shown for exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module firewall_rule_table_unit
  import fwrt_pkg::*;
#(
  parameter int MAX_RULES = MAX_RULES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  req_t      cmd,
  output logic      done,
  output rsp_t      result
);

  localparam int IDXW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW   = $clog2(MAX_RULES + 1);

  state_t          state;
  state_t          state_next;
  req_t            req;
  rule_t           query;
  logic            rule_ok;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            full;

  rule_t           rules [MAX_RULES];
  logic            match [MAX_RULES];
  cell_ctrl_t      ctrl  [MAX_RULES];

  logic [MAX_RULES-1:0] mvec;
  logic [MAX_RULES-1:0] iso;
  logic [IDXW-1:0]      idx_enc;
  logic                 found;
  logic [IDXW-1:0]      pick_idx;
  logic [MAX_RULES-1:0] ge_mask;
  logic [15:0]          idx_wide;
  rsp_t                 result_next;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    case (state)
      ST_IDLE:  state_next = start ? ST_CMP : ST_IDLE;
      ST_CMP:   state_next = ST_PICK;
      ST_PICK:  state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Command capture; a single rule carries zero upper bounds.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= '{op: cmd.op, is_range: cmd.is_range, addr_low: cmd.addr_low,
               addr_high: cmd.is_range ? cmd.addr_high : 32'd0,
               port_low: cmd.port_low,
               port_high: cmd.is_range ? cmd.port_high : 16'd0};
    end
  end

  assign query = '{range_flag: req.is_range, addr_low: req.addr_low,
                   addr_high: req.addr_high, port_low: req.port_low,
                   port_high: req.port_high};

  // Rule validity, registered alongside the cell compares.
  always_ff @(posedge clk) begin
    rule_ok <= !req.is_range ||
               ((req.addr_low < req.addr_high) && (req.port_low < req.port_high));
  end

  // Chain of cells; each cell but the last shifts in from its upper neighbor.
  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    if (g == MAX_RULES - 1) begin : g_last
      fwrt_cell u_cell (
        .clk        (clk),
        .query      (query),
        .check_mode (req.op == OP_CHECK),
        .ctrl       (ctrl[g]),
        .upper_rule (rules[g]),
        .rule       (rules[g]),
        .match      (match[g])
      );
    end else begin : g_mid
      fwrt_cell u_cell (
        .clk        (clk),
        .query      (query),
        .check_mode (req.op == OP_CHECK),
        .ctrl       (ctrl[g]),
        .upper_rule (rules[g+1]),
        .rule       (rules[g]),
        .match      (match[g])
      );
    end
  end

  // Only cells below the fill count take part.
  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      mvec[i] = match[i] && (CW'(i) < count);
    end
  end

  // Isolate the lowest match and encode its position.
  assign iso = mvec & (~mvec + {{(MAX_RULES-1){1'b0}}, 1'b1});

  always_comb begin
    idx_enc = '0;
    for (int i = 0; i < MAX_RULES; i++) begin
      if (iso[i]) begin
        idx_enc = idx_enc | IDXW'(i);
      end
    end
  end

  // Pick stage register.
  always_ff @(posedge clk) begin
    if (state == ST_PICK) begin
      found    <= |mvec;
      pick_idx <= idx_enc;
      ge_mask  <= ~(iso - {{(MAX_RULES-1){1'b0}}, 1'b1});
    end
  end

  assign full = (count == CW'(MAX_RULES));

  // Cell write controls for the apply step.
  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      ctrl[i].load  = (state == ST_APPLY) && (req.op == OP_ADD) && rule_ok && !full &&
                      (CW'(i) == count);
      ctrl[i].shift = (state == ST_APPLY) && (req.op == OP_DEL) && rule_ok && found &&
                      ge_mask[i];
    end
  end

  assign idx_wide = 16'(pick_idx);

  // Result and fill count for the apply step.
  always_comb begin
    result_next = '0;
    count_next  = count;
    case (op_e'(req.op))
      OP_ADD: begin
        if (!rule_ok) begin
          result_next.status = STS_INVALID;
        end else if (full) begin
          result_next.status = STS_FULL;
        end else begin
          result_next.status = STS_ADDED;
          count_next         = count + 1'b1;
        end
      end
      OP_DEL: begin
        if (!rule_ok) begin
          result_next.status = STS_INVALID;
        end else if (found) begin
          result_next.status = STS_DELETED;
          count_next         = count - 1'b1;
        end else begin
          result_next.status = STS_NOTFOUND;
        end
      end
      OP_CHECK: begin
        if (found) begin
          result_next.status      = STS_ACCEPTED;
          result_next.match_index = idx_wide[5:0];
        end else begin
          result_next.status = STS_REJECTED;
        end
      end
      OP_FLUSH: begin
        result_next.status = STS_FLUSHED;
        count_next         = '0;
      end
      default: begin
        result_next.status = STS_INVALID;
      end
    endcase
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == ST_APPLY) begin
      count <= count_next;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_APPLY);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/fwrt_cell.sv
// ----------------------------------------------------------------------------
// Firewall rule table cell
// Holds one rule, compares it against the current command and takes a new
// rule or its upper neighbor's rule when told to.
// ----------------------------------------------------------------------------
`default_nettype none

module fwrt_cell
  import fwrt_pkg::*;
(
  input  wire logic       clk,
  input  rule_t           query,
  input  wire logic       check_mode,
  input  cell_ctrl_t      ctrl,
  input  rule_t           upper_rule,
  output rule_t           rule,
  output logic            match
);

  logic hit;
  logic same;

  // Check: exact hit for a single rule, inside both ranges for a range rule.
  always_comb begin
    if (rule.range_flag) begin
      hit = (query.addr_low >= rule.addr_low) && (query.addr_low <= rule.addr_high) &&
            (query.port_low >= rule.port_low) && (query.port_low <= rule.port_high);
    end else begin
      hit = (query.addr_low == rule.addr_low) && (query.port_low == rule.port_low);
    end
  end

  // Delete: same kind and equal fields; the upper bounds count only for ranges.
  always_comb begin
    same = (rule.range_flag == query.range_flag) &&
           (rule.addr_low == query.addr_low) && (rule.port_low == query.port_low);
    if (query.range_flag) begin
      same = same && (rule.addr_high == query.addr_high) &&
             (rule.port_high == query.port_high);
    end
  end

  // Compare result is registered every cycle.
  always_ff @(posedge clk) begin
    match <= check_mode ? hit : same;
  end

  // Rule storage: append or shift down from the neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rule <= query;
    end else if (ctrl.shift) begin
      rule <= upper_rule;
    end
  end

endmodule

`default_nettype wire

// File: hdl/fwrt_checker.sv
// ----------------------------------------------------------------------------
// Firewall rule table checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fwrt_checker
  import fwrt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input rsp_t      result
);

  // An accepted command yields its result strobe after the compare, pick and apply states.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result strobe missing four cycles after command");

  // The unit is busy right after accepting a command.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command");

  // A result comes only when the unit is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Only an accepted check carries a nonzero index.
  a_index: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STS_ACCEPTED)) |-> (result.match_index == 6'd0))
    else $error("nonzero index on a result other than accepted");

endmodule

bind firewall_rule_table_unit fwrt_checker u_fwrt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Firewall rule table unit testbench
// Drives add, delete, check and flush commands through the start/busy
// handshake. A cycle-free predictor keeps its own copy of the rule table and
// predicts each verdict. A monitor compares every done strobe, field by field,
// against the oldest predicted verdict. Sender idling varies by phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import fwrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = MAX_RULES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_GAP     = 40;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t cmd;
  logic done;
  rsp_t result;

  firewall_rule_table_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #10 clk = ~clk;

  // Shadow copy of the rule table, updated when each command is accepted.
  rule_t       shadow_rules [TABLE_DEPTH];
  int unsigned shadow_count;

  rsp_t pending_verdicts [$];
  int   n_errors;
  int   idle_pct;
  int   stall_cycles;

  // Predict the verdict of one command and update the shadow table.
  function automatic rsp_t apply_rule_cmd(input req_t c);
    rsp_t  r;
    rule_t nr;
    logic  valid;
    int    hit;
    r.status      = STS_INVALID;
    r.match_index = '0;
    hit           = -1;
    nr.range_flag = c.is_range;
    nr.addr_low   = c.addr_low;
    nr.addr_high  = c.is_range ? c.addr_high : 32'd0;
    nr.port_low   = c.port_low;
    nr.port_high  = c.is_range ? c.port_high : 16'd0;
    valid = !c.is_range || ((c.addr_low < c.addr_high) && (c.port_low < c.port_high));
    case (op_e'(c.op))
      OP_ADD: begin
        if (!valid) begin
          r.status = STS_INVALID;
        end else if (shadow_count >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          shadow_rules[shadow_count] = nr;
          shadow_count++;
          r.status = STS_ADDED;
        end
      end
      OP_DEL: begin
        if (!valid) begin
          r.status = STS_INVALID;
        end else begin
          r.status = STS_NOTFOUND;
          // A single rule is identified by its low fields, a range rule by all four.
          for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_rules[i].range_flag == nr.range_flag &&
                shadow_rules[i].addr_low == nr.addr_low &&
                shadow_rules[i].port_low == nr.port_low &&
                (!nr.range_flag || (shadow_rules[i].addr_high == nr.addr_high &&
                                    shadow_rules[i].port_high == nr.port_high)))
              hit = i;
          end
          if (hit >= 0) begin
            for (int j = hit; j + 1 < shadow_count; j++)
              shadow_rules[j] = shadow_rules[j + 1];
            shadow_count--;
            r.status = STS_DELETED;
          end
        end
      end
      OP_CHECK: begin
        r.status = STS_REJECTED;
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0) begin
            if (shadow_rules[i].range_flag) begin
              if (c.addr_low >= shadow_rules[i].addr_low &&
                  c.addr_low <= shadow_rules[i].addr_high &&
                  c.port_low >= shadow_rules[i].port_low &&
                  c.port_low <= shadow_rules[i].port_high)
                hit = i;
            end else if (c.addr_low == shadow_rules[i].addr_low &&
                         c.port_low == shadow_rules[i].port_low) begin
              hit = i;
            end
          end
        end
        if (hit >= 0) begin
          r.status      = STS_ACCEPTED;
          r.match_index = hit[5:0];
        end
      end
      default: begin
        shadow_count = 0;
        r.status     = STS_FLUSHED;
      end
    endcase
    return r;
  endfunction

  // A command with every field random, used as filler for ignored fields.
  function automatic req_t random_cmd();
    req_t c;
    c.op        = 2'($urandom_range(3));
    c.is_range  = 1'($urandom_range(1));
    c.addr_low  = $urandom;
    c.addr_high = $urandom;
    c.port_low  = 16'($urandom_range(65535));
    c.port_high = 16'($urandom_range(65535));
    return c;
  endfunction

  // Addresses and ports come mostly from a small pool so that rules collide.
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(99) < 65)
      return 32'hC0A8_0000 | 32'($urandom_range(15));
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(4))
      0: return 16'd80;
      1: return 16'd443;
      2: return 16'd22;
      3: return 16'd8080;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // A uniformly chosen value inside an inclusive range.
  function automatic logic [31:0] point_in(input logic [31:0] lo, input logic [31:0] hi);
    longint unsigned span;
    span = longint'({32'd0, hi}) - longint'({32'd0, lo}) + 1;
    return lo + 32'({$urandom, $urandom} % span);
  endfunction

  function automatic req_t make_single(input op_e o, input logic [31:0] a,
                                       input logic [15:0] p);
    req_t c;
    c          = random_cmd();
    c.op       = o;
    c.is_range = 1'b0;
    c.addr_low = a;
    c.port_low = p;
    return c;
  endfunction

  function automatic req_t make_range(input op_e o, input logic [31:0] al,
                                      input logic [31:0] ah, input logic [15:0] pl,
                                      input logic [15:0] ph);
    req_t c;
    c           = random_cmd();
    c.op        = o;
    c.is_range  = 1'b1;
    c.addr_low  = al;
    c.addr_high = ah;
    c.port_low  = pl;
    c.port_high = ph;
    return c;
  endfunction

  function automatic req_t make_query(input logic [31:0] a, input logic [15:0] p);
    req_t c;
    c          = random_cmd();
    c.op       = OP_CHECK;
    c.addr_low = a;
    c.port_low = p;
    return c;
  endfunction

  function automatic req_t make_flush();
    req_t c;
    c    = random_cmd();
    c.op = OP_FLUSH;
    return c;
  endfunction

  // A random rule, mostly well formed; about three ranges in twenty are broken.
  function automatic req_t rand_rule(input op_e o);
    req_t        c;
    logic [31:0] a0, a1, at;
    logic [15:0] p0, p1, pt;
    c          = random_cmd();
    c.op       = o;
    c.is_range = 1'($urandom_range(1));
    c.addr_low = pick_addr();
    c.port_low = pick_port();
    if (c.is_range) begin
      a0 = pick_addr();
      a1 = pick_addr();
      if (a0 > a1) begin
        at = a0; a0 = a1; a1 = at;
      end
      if (a0 == a1) begin
        if (a1 != '1) a1 = a1 + 1;
        else a0 = a0 - 1;
      end
      p0 = pick_port();
      p1 = pick_port();
      if (p0 > p1) begin
        pt = p0; p0 = p1; p1 = pt;
      end
      if (p0 == p1) begin
        if (p1 != '1) p1 = p1 + 1;
        else p0 = p0 - 1;
      end
      case ($urandom_range(19))
        0: a1 = a0;
        1: begin at = a0; a0 = a1; a1 = at; end
        2: p1 = p0;
        default: ;
      endcase
      c.addr_low  = a0;
      c.addr_high = a1;
      c.port_low  = p0;
      c.port_high = p1;
    end
    return c;
  endfunction

  // Hold start low for a random number of cycles according to the idle phase.
  task automatic pause_sender();
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      cmd   = random_cmd();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Present one command, wait until it is accepted, and record its verdict.
  task automatic send_cmd(input req_t c);
    @(negedge clk);
    start = 1'b1;
    cmd   = c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_verdicts.push_back(apply_rule_cmd(c));
    pause_sender();
  endtask

  // Extremes, every operation and the special cases of add and delete.
  task automatic test_directed();
    idle_pct = 0;
    send_cmd(make_flush());
    send_cmd(make_query(32'd0, 16'd0));
    send_cmd(make_single(OP_ADD, 32'd0, 16'd0));
    send_cmd(make_single(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF));
    send_cmd(make_range(OP_ADD, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF));
    send_cmd(make_range(OP_ADD, 32'd5, 32'd5, 16'd1, 16'd2));
    send_cmd(make_range(OP_ADD, 32'd5, 32'd9, 16'd7, 16'd3));
    send_cmd(make_query(32'hFFFF_FFFF, 16'hFFFF));
    send_cmd(make_query(32'h1234_5678, 16'd80));
    send_cmd(make_query(32'd0, 16'd0));
    send_cmd(make_range(OP_DEL, 32'd10, 32'd20, 16'd1, 16'd2));
    send_cmd(make_range(OP_ADD, 32'd100, 32'd200, 16'd10, 16'd20));
    // A single rule never deletes a range rule with the same low fields.
    send_cmd(make_single(OP_DEL, 32'd100, 16'd10));
    send_cmd(make_range(OP_DEL, 32'd200, 32'd100, 16'd10, 16'd20));
    send_cmd(make_single(OP_DEL, 32'd0, 16'd0));
    send_cmd(make_query(32'hFFFF_FFFF, 16'hFFFF));
    send_cmd(make_range(OP_DEL, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF));
    send_cmd(make_query(32'd150, 16'd15));
    send_cmd(make_query(32'd200, 16'd21));
    send_cmd(make_single(OP_DEL, 32'hFFFF_FFFF, 16'hFFFF));
    send_cmd(make_query(32'd100, 16'd10));
    send_cmd(make_flush());
    send_cmd(make_query(32'd150, 16'd15));
  endtask

  // Fill the table, hit the last entry, and try adds against a full table.
  task automatic test_table_full();
    idle_pct = 29;
    send_cmd(make_flush());
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      send_cmd(make_single(OP_ADD, 32'h0A00_0000 + i, 16'(1000 + i)));
    send_cmd(make_range(OP_ADD, 32'hF000_0000, 32'hF000_00FF, 16'd1000, 16'd2000));
    send_cmd(make_single(OP_ADD, 32'h0B00_0000, 16'd1));
    send_cmd(make_range(OP_ADD, 32'd7, 32'd3, 16'd1, 16'd2));
    send_cmd(make_query(32'hF000_0080, 16'd1500));
    send_cmd(make_single(OP_DEL, 32'h0A00_0005, 16'd1005));
    send_cmd(make_query(32'hF000_00FF, 16'd2000));
    send_cmd(make_single(OP_ADD, 32'h0B00_0000, 16'd1));
    send_cmd(make_single(OP_ADD, 32'h0B00_0001, 16'd1));
    send_cmd(make_flush());
  endtask

  // Random traffic over several idling phases.
  task automatic test_random_traffic();
    int    phase_pct [4];
    req_t  c;
    rule_t pick;
    int    sel;
    phase_pct = '{0, 85, 29, 0};
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      repeat (415) begin
        sel = $urandom_range(99);
        if (sel < 35) begin
          c = rand_rule(OP_ADD);
        end else if (sel < 55) begin
          c = rand_rule(OP_DEL);
          // Most deletes name a rule that is present.
          if (shadow_count > 0 && $urandom_range(99) < 60) begin
            pick        = shadow_rules[$urandom_range(shadow_count - 1)];
            c.is_range  = pick.range_flag;
            c.addr_low  = pick.addr_low;
            c.port_low  = pick.port_low;
            if (pick.range_flag) begin
              c.addr_high = pick.addr_high;
              c.port_high = pick.port_high;
            end
          end
        end else if (sel < 97) begin
          c = make_query(pick_addr(), pick_port());
          // Half the queries land inside a rule that is present.
          if (shadow_count > 0 && $urandom_range(1)) begin
            pick = shadow_rules[$urandom_range(shadow_count - 1)];
            if (pick.range_flag) begin
              c.addr_low = point_in(pick.addr_low, pick.addr_high);
              c.port_low = 16'(point_in({16'd0, pick.port_low}, {16'd0, pick.port_high}));
            end else begin
              c.addr_low = pick.addr_low;
              c.port_low = pick.port_low;
            end
          end
        end else begin
          c = make_flush();
        end
        send_cmd(c);
      end
    end
  endtask

  // Compare each result transaction with the oldest predicted verdict.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no command outstanding: status %0d, match_index %0d",
               result.status, result.match_index);
        n_errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result.status);
          n_errors++;
        end
        if (result.match_index !== want.match_index) begin
          $error("match_index: expected %0d, actual %0d", want.match_index,
                 result.match_index);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without an accepted command.
  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    n_errors     = 0;
    idle_pct     = 0;
    shadow_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_table_full();
    test_random_traffic();

    @(negedge clk);
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", pending_verdicts.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: firewall_rule_table_unit.f
hdl/fwrt_pkg.sv
hdl/fwrt_cell.sv
hdl/firewall_rule_table_unit.sv
hdl/fwrt_checker.sv
tb/tb.sv
